FILE: hw/rtl/q2e_pkg.sv
// Shared constants, types and elaboration-time helpers for the quaternion to Euler block.
// Used by every file under hw/rtl; depends on nothing.
package q2e_pkg;

  localparam int QUAT_FRAC_BITS  = 14;
  localparam int ANGLE_FRAC_BITS = 7;
  localparam int CORDIC_STAGES   = 16;

  localparam int QUAT_W   = 16;
  localparam int ANGLE_W  = 16;
  localparam int ORDER_W  = 3;
  localparam int PROD_W   = 2 * QUAT_W;
  localparam int SUM_W    = PROD_W + 1;
  localparam int ASIN_W   = 32;   // asin argument, Q30, clamped to +-1.0
  localparam int ASIN_FB  = 30;
  localparam int ROOT_W   = 31;   // floor root of a value up to 2^60
  localparam int CORDIC_W = 43;
  localparam int Z_W      = 36;   // radians, Q32
  localparam int NORM_TOP = 39;   // leading one of the larger magnitude ends at this bit
  localparam int NORM_STEPS = 6;  // shift steps of 32, 16, 8, 4, 2, 1
  localparam int MAX_CORDIC = 32;
  localparam int SQRT_LATENCY = 2 + ROOT_W;

  localparam longint DEG_PER_RAD_Q24 = 64'd961263669;
  localparam longint PI_Q32          = 64'd13493037705;
  localparam longint HALF_PI_Q32     = 64'd6746518852;
  localparam longint PI4_Q32         = 64'd3373259426;

  typedef enum logic [ORDER_W-1:0] {
    ORD_ZYX = 3'd0,
    ORD_XYZ = 3'd1,
    ORD_YZX = 3'd2,
    ORD_XZY = 3'd3,
    ORD_YXZ = 3'd4,
    ORD_ZXY = 3'd5
  } order_t;

  // Width of the atan2 operands: room for 1.0 at 2*qf fraction bits and the doubled sums
  function automatic int op_width(int qf);
    return (2 * qf + 3 > 36) ? 2 * qf + 3 : 36;
  endfunction

  function automatic int norm_width(int opw);
    return (opw > NORM_TOP + 2) ? opw : NORM_TOP + 2;
  endfunction

  function automatic int cordic_count(int n);
    return (n < MAX_CORDIC) ? n : MAX_CORDIC;
  endfunction

  // Input register, shift steps, rotations, quadrant fix-up, three scaling stages
  function automatic int atan_latency(int n);
    return 2 * NORM_STEPS + cordic_count(n) + 5;
  endfunction

  // Floor quotient by restoring long division, one quotient bit per step
  function automatic longint unsigned udiv(longint unsigned n, longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in Q32, from an exact Q60 series rounded to 32 fraction bits
  function automatic longint atan_q32(int i);
    longint unsigned term;
    longint sum;
    int e;
    sum = 0;
    for (int k = 0; k < 64; k++) begin
      e = i * (2 * k + 1);
      if (e <= 60) begin
        term = udiv(64'd1 << (60 - e), 64'(2 * k + 1));
        sum = sum + (k[0] ? -longint'(term) : longint'(term));
      end
    end
    if (i == 0) return PI4_Q32;
    return (sum + (64'sd1 <<< 27)) >>> 28;
  endfunction

endpackage

FILE: hw/rtl/q2e_in_if.sv
// Input channel: one quaternion and an axis-order code per beat.
// Depends on q2e_pkg for field widths.
interface q2e_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [q2e_pkg::QUAT_W-1:0]   quat_x;
  logic signed [q2e_pkg::QUAT_W-1:0]   quat_y;
  logic signed [q2e_pkg::QUAT_W-1:0]   quat_z;
  logic signed [q2e_pkg::QUAT_W-1:0]   quat_w;
  logic        [q2e_pkg::ORDER_W-1:0]  rotation_order;

  modport source (output valid, quat_x, quat_y, quat_z, quat_w, rotation_order, input ready);
  modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, rotation_order, output ready);
endinterface

FILE: hw/rtl/q2e_out_if.sv
// Output channel: three Euler angles in degrees per beat.
// Depends on q2e_pkg for field widths.
interface q2e_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [q2e_pkg::ANGLE_W-1:0] angle_x;
  logic signed [q2e_pkg::ANGLE_W-1:0] angle_y;
  logic signed [q2e_pkg::ANGLE_W-1:0] angle_z;

  modport source (output valid, angle_x, angle_y, angle_z, input ready);
  modport sink   (input valid, angle_x, angle_y, angle_z, output ready);
endinterface

FILE: hw/rtl/q2e_sqrt.sv
// Pipelined floor square root of 1.0 - s^2 for the arcsine path, one root bit per stage.
// Depends on q2e_pkg.
module q2e_sqrt (
  input  logic                           clk,
  input  logic                           en,
  input  logic [q2e_pkg::ROOT_W-1:0]     mag,
  output logic [q2e_pkg::ROOT_W-1:0]     root
);
  localparam int RW = q2e_pkg::ROOT_W;
  localparam int SQ_W = 2 * RW;
  localparam int REM_W = 2 * RW + 1;

  logic [SQ_W-1:0]  sq;
  logic [SQ_W-1:0]  rad;
  logic [REM_W-1:0] rem [RW];
  logic [RW-1:0]    rt [RW];

  // Square, then subtract from 1.0 at 60 fraction bits
  always_ff @(posedge clk) begin
    if (en) begin
      sq  <= SQ_W'(mag) * SQ_W'(mag);
      rad <= (SQ_W'(1) << (2 * q2e_pkg::ASIN_FB)) - sq;
    end
  end

  // Settle one root bit per stage, most significant first
  for (genvar j = 0; j < RW; j++) begin : g_bit
    localparam int K = RW - 1 - j;
    logic [REM_W-1:0] rem_i;
    logic [RW-1:0]    rt_i;
    logic [REM_W-1:0] trial;
    if (j == 0) begin : g_first
      always_comb begin
        rem_i = REM_W'(rad);
        rt_i  = '0;
      end
    end else begin : g_next
      always_comb begin
        rem_i = rem[j-1];
        rt_i  = rt[j-1];
      end
    end
    always_comb trial = (REM_W'(rt_i) << (K + 1)) + (REM_W'(1) << (2 * K));
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_i >= trial) begin
          rem[j] <= rem_i - trial;
          rt[j]  <= rt_i | (RW'(1) << K);
        end else begin
          rem[j] <= rem_i;
          rt[j]  <= rt_i;
        end
      end
    end
  end

  assign root = rt[RW-1];
endmodule

FILE: hw/rtl/q2e_atan2.sv
// Pipelined atan2 lane: magnitude normalize, vectoring CORDIC, quadrant fix-up, and
// conversion of the negated angle to saturated degrees. Depends on q2e_pkg.
module q2e_atan2 #(
  parameter int OP_W            = 36,
  parameter int ANGLE_FRAC_BITS = q2e_pkg::ANGLE_FRAC_BITS,
  parameter int CORDIC_STAGES   = q2e_pkg::CORDIC_STAGES
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [OP_W-1:0]             num,
  input  logic signed [OP_W-1:0]             den,
  output logic signed [q2e_pkg::ANGLE_W-1:0] angle
);
  localparam int NW  = q2e_pkg::norm_width(OP_W);
  localparam int NC  = q2e_pkg::cordic_count(CORDIC_STAGES);
  localparam int NLV = 2 * q2e_pkg::NORM_STEPS;
  localparam int CW  = q2e_pkg::CORDIC_W;
  localparam int ZW  = q2e_pkg::Z_W;
  localparam int AW  = q2e_pkg::ANGLE_W;
  localparam int SH  = 56 - ANGLE_FRAC_BITS;
  localparam int MAG_W  = 34;
  localparam int HALF_W = 17;
  localparam int C_W    = 30;
  localparam int PP_W   = HALF_W + C_W;
  localparam int ACC_W  = 65;
  localparam int R_W    = 30;
  localparam logic [C_W-1:0]       DEG_C   = C_W'(q2e_pkg::DEG_PER_RAD_Q24);
  localparam logic signed [ZW-1:0] PI_Z    = ZW'(q2e_pkg::PI_Q32);
  localparam logic signed [ZW-1:0] HALF_PI = ZW'(q2e_pkg::HALF_PI_Q32);
  localparam logic [R_W-1:0]       NEG_LIM = R_W'(32768);
  localparam logic [R_W-1:0]       POS_LIM = R_W'(32767);
  localparam logic signed [AW-1:0] POS_MAX = AW'(32767);

  typedef struct packed {
    logic num_neg;
    logic den_neg;
    logic ay_zero;
    logic ax_zero;
  } flags_t;

  logic [OP_W-1:0] ax_in, ay_in;
  logic [NW-1:0]   nax [NLV+1];
  logic [NW-1:0]   nay [NLV+1];
  logic [NW-1:0]   nm  [NLV+1];
  flags_t          nfl [NLV+1];

  logic signed [CW-1:0] cx [NC];
  logic signed [CW-1:0] cy [NC];
  logic signed [ZW-1:0] cz [NC];
  flags_t               cfl [NC];

  logic signed [ZW-1:0] theta, ang_c, ang_q;
  logic [MAG_W-1:0]     mag;
  logic [PP_W-1:0]      pp_hi, pp_lo;
  logic                 pos1, pos2;
  logic [ACC_W-1:0]     acc;
  logic [R_W-1:0]       deg;
  logic [AW-1:0]        neg_mag;

  // Take magnitudes and the larger of the two
  always_comb begin
    ax_in = den[OP_W-1] ? OP_W'(-den) : OP_W'(den);
    ay_in = num[OP_W-1] ? OP_W'(-num) : OP_W'(num);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nax[0] <= NW'(ax_in);
      nay[0] <= NW'(ay_in);
      nm[0]  <= NW'((ax_in > ay_in) ? ax_in : ay_in);
      nfl[0] <= '{num_neg: num[OP_W-1], den_neg: den[OP_W-1],
                  ay_zero: (ay_in == '0), ax_zero: (ax_in == '0)};
    end
  end

  // Bring the leading one to NORM_TOP: right steps first, then left steps
  for (genvar j = 0; j < NLV; j++) begin : g_norm
    localparam int SFT = 32 >> (j % q2e_pkg::NORM_STEPS);
    localparam bit RIGHT = (j < q2e_pkg::NORM_STEPS);
    logic do_sft;
    always_comb begin
      if (RIGHT) do_sft = (nm[j] >> (q2e_pkg::NORM_TOP + SFT)) != '0;
      else       do_sft = (nm[j] >> (q2e_pkg::NORM_TOP + 1 - SFT)) == '0;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (!do_sft) begin
          nax[j+1] <= nax[j];
          nay[j+1] <= nay[j];
          nm[j+1]  <= nm[j];
        end else if (RIGHT) begin
          nax[j+1] <= nax[j] >> SFT;
          nay[j+1] <= nay[j] >> SFT;
          nm[j+1]  <= nm[j] >> SFT;
        end else begin
          nax[j+1] <= nax[j] << SFT;
          nay[j+1] <= nay[j] << SFT;
          nm[j+1]  <= nm[j] << SFT;
        end
        nfl[j+1] <= nfl[j];
      end
    end
  end

  // Vectoring rotations, one per stage
  for (genvar i = 0; i < NC; i++) begin : g_cordic
    localparam logic signed [ZW-1:0] T = ZW'(q2e_pkg::atan_q32(i));
    logic signed [CW-1:0] xi, yi;
    logic signed [ZW-1:0] zi;
    flags_t               fi;
    if (i == 0) begin : g_first
      always_comb begin
        xi = CW'(nax[NLV]);
        yi = CW'(nay[NLV]);
        zi = '0;
        fi = nfl[NLV];
      end
    end else begin : g_next
      always_comb begin
        xi = cx[i-1];
        yi = cy[i-1];
        zi = cz[i-1];
        fi = cfl[i-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (yi > 0) begin
          cx[i] <= xi + (yi >>> i);
          cy[i] <= yi - (xi >>> i);
          cz[i] <= zi + T;
        end else begin
          cx[i] <= xi - (yi >>> i);
          cy[i] <= yi + (xi >>> i);
          cz[i] <= zi - T;
        end
        cfl[i] <= fi;
      end
    end
  end

  // Axis cases and quadrant fix-up
  always_comb begin
    if (cfl[NC-1].ay_zero)      theta = '0;
    else if (cfl[NC-1].ax_zero) theta = HALF_PI;
    else                        theta = cz[NC-1];
    ang_c = cfl[NC-1].den_neg ? PI_Z - theta : theta;
    if (cfl[NC-1].num_neg) ang_c = -ang_c;
  end

  always_comb mag = ang_q[ZW-1] ? MAG_W'(-ang_q) : MAG_W'(ang_q);

  // Scale to degrees in two partial products, round, then negate and saturate
  always_ff @(posedge clk) begin
    if (en) begin
      ang_q <= ang_c;
      pp_hi <= PP_W'(mag[MAG_W-1:HALF_W]) * PP_W'(DEG_C);
      pp_lo <= PP_W'(mag[HALF_W-1:0]) * PP_W'(DEG_C);
      pos1  <= (ang_q > 0);
      acc   <= (ACC_W'(pp_hi) << HALF_W) + ACC_W'(pp_lo) + (ACC_W'(1) << (SH - 1));
      pos2  <= pos1;
      if (pos2) angle <= -$signed(neg_mag);
      else      angle <= (deg > POS_LIM) ? POS_MAX : $signed(AW'(deg));
    end
  end

  always_comb begin
    deg     = R_W'(acc >> SH);
    neg_mag = (deg > NEG_LIM) ? AW'(NEG_LIM) : AW'(deg);
  end
endmodule

FILE: hw/rtl/quaternion_to_euler_six_orders_top.sv
// Quaternion to Euler angles, six axis orders: products, operand select, asin root, 3 atan2 lanes.
// One beat per cycle while the output register does not hold an untaken beat.
// The whole pipeline advances unless the output register holds an untaken beat.
// Synchronous active-high reset clears the valid bits only; data registers are not reset.
// Depends on q2e_pkg, q2e_in_if, q2e_out_if, q2e_sqrt and q2e_atan2.
module quaternion_to_euler_six_orders_top #(
  parameter int QUAT_FRAC_BITS  = q2e_pkg::QUAT_FRAC_BITS,
  parameter int ANGLE_FRAC_BITS = q2e_pkg::ANGLE_FRAC_BITS,
  parameter int CORDIC_STAGES   = q2e_pkg::CORDIC_STAGES
) (
  input logic      clk,
  input logic      rst,
  q2e_in_if.sink   quat,
  q2e_out_if.source euler
);
  localparam int OP_W   = q2e_pkg::op_width(QUAT_FRAC_BITS);
  localparam int FB     = 2 * QUAT_FRAC_BITS;
  localparam int RSH    = (FB >= q2e_pkg::ASIN_FB) ? FB - q2e_pkg::ASIN_FB : 0;
  localparam int LSH    = (FB < q2e_pkg::ASIN_FB) ? q2e_pkg::ASIN_FB - FB : 0;
  localparam int SQ_LAT = q2e_pkg::SQRT_LATENCY;
  localparam int AT_LAT = q2e_pkg::atan_latency(CORDIC_STAGES);
  localparam int TOT    = 5 + SQ_LAT + AT_LAT;
  localparam int PW     = q2e_pkg::PROD_W;
  localparam int SW     = q2e_pkg::SUM_W;
  localparam int VW     = q2e_pkg::ASIN_W;
  localparam int RW     = q2e_pkg::ROOT_W;
  localparam int AW     = q2e_pkg::ANGLE_W;
  localparam logic signed [OP_W-1:0] ONE   = OP_W'(1) << FB;
  localparam logic signed [63:0]     S_MAX = 64'sd1 <<< q2e_pkg::ASIN_FB;

  typedef struct packed {
    logic signed [OP_W-1:0] num_a;
    logic signed [OP_W-1:0] den_a;
    logic signed [OP_W-1:0] num_b;
    logic signed [OP_W-1:0] den_b;
    logic signed [VW-1:0]   s;
    q2e_pkg::order_t        ord;
  } side_t;

  logic           en;
  logic [TOT-1:0] vld;

  logic signed [PW-1:0] p00, p11, p22, p01, p02, p12, p30, p31, p32;
  q2e_pkg::order_t      ord1, ord2, ord3;
  logic signed [SW-1:0] s12m, s12p, s02m, s02p, s01m, s01p;
  logic signed [OP_W-1:0] d01, d02, d12;
  logic signed [OP_W-1:0] num_a3, den_a3, num_b3, den_b3, v3;
  logic signed [OP_W-1:0] t12m, t12p, t02m, t02p, t01m, t01p;
  logic signed [63:0]   sc;
  logic signed [VW-1:0] s_clamp;
  side_t                side_p4;
  logic [RW-1:0]        mv_p4;
  side_t                side_d [SQ_LAT];
  logic [RW-1:0]        root;
  side_t                side_q;
  logic signed [OP_W-1:0] num_s, den_s;
  q2e_pkg::order_t      ord_d [AT_LAT];
  q2e_pkg::order_t      ord_o;
  logic signed [AW-1:0] ang_a, ang_b, ang_s;

  assign en         = !euler.valid || euler.ready;
  assign quat.ready = en;
  assign euler.valid = vld[TOT-1];

  // Valid bits move with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[TOT-2:0], quat.valid};
    end
  end

  // Products of the components
  always_ff @(posedge clk) begin
    if (en) begin
      p00  <= PW'(quat.quat_x) * PW'(quat.quat_x);
      p11  <= PW'(quat.quat_y) * PW'(quat.quat_y);
      p22  <= PW'(quat.quat_z) * PW'(quat.quat_z);
      p01  <= PW'(quat.quat_x) * PW'(quat.quat_y);
      p02  <= PW'(quat.quat_x) * PW'(quat.quat_z);
      p12  <= PW'(quat.quat_y) * PW'(quat.quat_z);
      p30  <= PW'(quat.quat_w) * PW'(quat.quat_x);
      p31  <= PW'(quat.quat_w) * PW'(quat.quat_y);
      p32  <= PW'(quat.quat_w) * PW'(quat.quat_z);
      ord1 <= q2e_pkg::order_t'(quat.rotation_order);
    end
  end

  // Pair sums and diagonal terms
  always_ff @(posedge clk) begin
    if (en) begin
      s12m <= SW'(p12) - SW'(p30);
      s12p <= SW'(p12) + SW'(p30);
      s02m <= SW'(p02) - SW'(p31);
      s02p <= SW'(p02) + SW'(p31);
      s01m <= SW'(p01) - SW'(p32);
      s01p <= SW'(p01) + SW'(p32);
      d01  <= ONE - ((OP_W'(p00) + OP_W'(p11)) <<< 1);
      d02  <= ONE - ((OP_W'(p00) + OP_W'(p22)) <<< 1);
      d12  <= ONE - ((OP_W'(p11) + OP_W'(p22)) <<< 1);
      ord2 <= ord1;
    end
  end

  // Pick the operands of the two atan2 lanes and the asin argument for this order
  always_comb begin
    t12m = OP_W'(s12m) <<< 1;
    t12p = -(OP_W'(s12p) <<< 1);
    t02m = OP_W'(s02m) <<< 1;
    t02p = -(OP_W'(s02p) <<< 1);
    t01m = OP_W'(s01m) <<< 1;
    t01p = -(OP_W'(s01p) <<< 1);
    num_a3 = '0;
    den_a3 = '0;
    num_b3 = '0;
    den_b3 = '0;
    v3     = '0;
    case (ord2)
      q2e_pkg::ORD_ZYX: begin
        num_a3 = t12m; den_a3 = d01; num_b3 = t01m; den_b3 = d12; v3 = t02p;
      end
      q2e_pkg::ORD_XYZ: begin
        num_a3 = t12p; den_a3 = d01; num_b3 = t01p; den_b3 = d12; v3 = t02m;
      end
      q2e_pkg::ORD_YZX: begin
        num_a3 = t12p; den_a3 = d02; num_b3 = t02p; den_b3 = d12; v3 = t01m;
      end
      q2e_pkg::ORD_XZY: begin
        num_a3 = t12m; den_a3 = d02; num_b3 = t02m; den_b3 = d12; v3 = t01p;
      end
      q2e_pkg::ORD_YXZ: begin
        num_a3 = t02m; den_a3 = d01; num_b3 = t01m; den_b3 = d02; v3 = t12p;
      end
      q2e_pkg::ORD_ZXY: begin
        num_a3 = t02p; den_a3 = d01; num_b3 = t01p; den_b3 = d02; v3 = t12m;
      end
      default: begin
        v3 = '0;
      end
    endcase
  end

  logic signed [OP_W-1:0] na_p3, da_p3, nb_p3, db_p3, v_p3;
  always_ff @(posedge clk) begin
    if (en) begin
      na_p3 <= num_a3;
      da_p3 <= den_a3;
      nb_p3 <= num_b3;
      db_p3 <= den_b3;
      v_p3  <= v3;
      ord3  <= ord2;
    end
  end

  // Bring the asin argument to Q30 and clamp it to +-1.0
  always_comb begin
    sc = (64'(v_p3) >>> RSH) <<< LSH;
    if (sc > S_MAX)       s_clamp = VW'(S_MAX);
    else if (sc < -S_MAX) s_clamp = VW'(-S_MAX);
    else                  s_clamp = VW'(sc);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_p4 <= '{num_a: na_p3, den_a: da_p3, num_b: nb_p3, den_b: db_p3,
                   s: s_clamp, ord: ord3};
      mv_p4   <= s_clamp[VW-1] ? RW'(-s_clamp) : RW'(s_clamp);
    end
  end

  q2e_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .mag  (mv_p4),
    .root (root)
  );

  // Hold the lane operands while the root settles
  always_ff @(posedge clk) begin
    if (en) begin
      side_d[0] <= side_p4;
      for (int k = 1; k < SQ_LAT; k++) side_d[k] <= side_d[k-1];
    end
  end

  always_comb begin
    side_q = side_d[SQ_LAT-1];
    num_s  = OP_W'(side_q.s);
    den_s  = OP_W'(signed'({1'b0, root}));
  end

  q2e_atan2 #(
    .OP_W(OP_W), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES)
  ) u_lane_a (
    .clk(clk), .en(en), .num(side_q.num_a), .den(side_q.den_a), .angle(ang_a)
  );

  q2e_atan2 #(
    .OP_W(OP_W), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES)
  ) u_lane_b (
    .clk(clk), .en(en), .num(side_q.num_b), .den(side_q.den_b), .angle(ang_b)
  );

  q2e_atan2 #(
    .OP_W(OP_W), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES)
  ) u_lane_s (
    .clk(clk), .en(en), .num(num_s), .den(den_s), .angle(ang_s)
  );

  // Carry the order code alongside the lanes
  always_ff @(posedge clk) begin
    if (en) begin
      ord_d[0] <= side_q.ord;
      for (int k = 1; k < AT_LAT; k++) ord_d[k] <= ord_d[k-1];
    end
  end

  // Route lane results to the axes; codes without meaning give zeros
  always_ff @(posedge clk) begin
    if (en) begin
      ord_o <= ord_d[AT_LAT-1];
      case (ord_d[AT_LAT-1])
        q2e_pkg::ORD_ZYX, q2e_pkg::ORD_XYZ: begin
          euler.angle_x <= ang_a; euler.angle_y <= ang_s; euler.angle_z <= ang_b;
        end
        q2e_pkg::ORD_YZX, q2e_pkg::ORD_XZY: begin
          euler.angle_x <= ang_a; euler.angle_y <= ang_b; euler.angle_z <= ang_s;
        end
        q2e_pkg::ORD_YXZ, q2e_pkg::ORD_ZXY: begin
          euler.angle_x <= ang_s; euler.angle_y <= ang_a; euler.angle_z <= ang_b;
        end
        default: begin
          euler.angle_x <= '0; euler.angle_y <= '0; euler.angle_z <= '0;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // A held result must block new beats
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    euler.valid && !euler.ready |-> !(quat.valid && quat.ready))
    else $error("beat accepted while the output was stalled");

  // Unknown order codes come out as zero angles
  a_bad_order_zero: assert property (@(posedge clk) disable iff (rst)
    euler.valid && !(ord_o == q2e_pkg::ORD_ZYX || ord_o == q2e_pkg::ORD_XYZ ||
                     ord_o == q2e_pkg::ORD_YZX || ord_o == q2e_pkg::ORD_XZY ||
                     ord_o == q2e_pkg::ORD_YXZ || ord_o == q2e_pkg::ORD_ZXY)
    |-> euler.angle_x == '0 && euler.angle_y == '0 && euler.angle_z == '0)
    else $error("nonzero angles for an unknown order");

  // Nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !euler.valid)
    else $error("output valid after reset");
`endif
endmodule
